// ----- rtl/vcps_pkg.sv -----
package vcps_pkg;

	localparam int MAX_PARTICLES = 64;

	// configuration register indexes
	localparam logic [2:0] REG_GRAVITY      = 3'd0;
	localparam logic [2:0] REG_CENTRE_X     = 3'd1;
	localparam logic [2:0] REG_CENTRE_Y     = 3'd2;
	localparam logic [2:0] REG_BOUND_RADIUS = 3'd3;
	localparam logic [2:0] REG_SUBSTEPS     = 3'd4;

	localparam logic REQ_INSERT  = 1'b0;
	localparam logic REQ_FRAME   = 1'b1;
	localparam logic KIND_ACK    = 1'b0;
	localparam logic KIND_POS    = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE, S_INS, S_SD, S_G1, S_G2, S_G3,
		S_BRD, S_BLD, S_PRA, S_PLA, S_PRB, S_PLB,
		S_M1, S_M2, S_M3, S_CMP, S_SQ, S_MX, S_DX0, S_DX,
		S_MY, S_DY0, S_DY, S_BNXT, S_PNXT, S_PWA,
		S_VRD, S_VWR, S_RRD, S_ROUT
	} state_t;

	typedef struct packed {
		logic              req_type;
		logic signed [23:0] spawn_x;
		logic signed [23:0] spawn_y;
		logic [5:0]        spawn_radius;
		logic [15:0]       frame_dt;
	} req_t;

	typedef struct packed {
		logic              kind;
		logic              status;
		logic [5:0]        slot;
		logic signed [23:0] out_x;
		logic signed [23:0] out_y;
		logic [5:0]        out_radius;
		logic              last;
	} rsp_t;

	function automatic logic signed [23:0] sat28(input logic signed [27:0] v);
		logic signed [23:0] r;
		if (v > 28'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -28'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/verlet_circle_particle_step.sv -----
// Verlet particle world of up to 64 circles in a circular bound. An insert is written to the
// store, unless it is full, once the result register is free. A frame first forms the substep
// time (a divide) and the gravity step, then per substep: a bound test for each particle, plus
// a square root and two divides for each particle that is outside; a test for each particle
// pair, plus a root and two divides for each overlapping pair; a position update for each
// particle. Reporting then returns one result per particle. Everything runs through one shared
// multiplier, one shift-subtract divider and one square-root unit, and one read port on the
// particle store. The block takes no new item until the current one is finished.
module verlet_circle_particle_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  vcps_pkg::req_t     req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output vcps_pkg::rsp_t     rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	vcps_pkg::state_t state_q, state_d;

	logic [23:0] grav_q;
	logic [11:0] cx_q, cy_q, brad_q;
	logic [4:0]  subs_q;
	logic [6:0]  cnt_q;

	logic [5:0]  i_q, i_d, a_q, a_d, b_q, b_d;
	logic [4:0]  step_q, step_d;
	logic        pair_q, pair_d;

	logic [23:0] sd_q;
	logic [24:0] gs_q;
	logic signed [23:0] px_q, py_q, qx_q, qy_q;
	logic [5:0]  ra_q;
	logic signed [24:0] dx_q, dy_q;
	logic [19:0] lim_q;
	logic [49:0] dsq_q;
	logic [25:0] mag_q;
	logic signed [25:0] sx_q;
	logic        neg_q;

	logic signed [32:0] mul_a;
	logic signed [25:0] mul_b;
	logic signed [58:0] prod_q;

	logic [47:0] dv_quo_q;
	logic [26:0] dv_rem_q;
	logic [25:0] dv_den_q;
	logic [5:0]  dv_cnt_q;
	logic        dv_load;
	logic [47:0] dv_num;
	logic [25:0] dv_den;
	logic [5:0]  dv_n;
	logic [26:0] dv_sh;
	logic        dv_ge;

	logic [49:0] sq_v_q;
	logic [50:0] sq_res_q;
	logic [48:0] sq_bit_q;
	logic        sq_load;
	logic [50:0] sq_sum;
	logic        sq_ge;

	logic [47:0] cur_mem  [vcps_pkg::MAX_PARTICLES];
	logic [47:0] prev_mem [vcps_pkg::MAX_PARTICLES];
	logic [5:0]  rad_mem  [vcps_pkg::MAX_PARTICLES];
	logic [5:0]  rd_addr;
	logic [47:0] cur_rd_q, prev_rd_q;
	logic [5:0]  rad_rd_q;
	logic        cur_we, prev_we, rad_we;
	logic [5:0]  wr_addr;
	logic [47:0] cur_wd, prev_wd;
	logic [5:0]  rad_wd;

	logic           rsp_load, rsp_valid_q, out_free;
	vcps_pkg::rsp_t rsp_d, rsp_q;

	logic [4:0]  n_sub;
	logic signed [23:0] rd_x, rd_y, prv_x, prv_y;
	logic signed [12:0] lim_raw;
	logic [6:0]  rsum;
	logic signed [26:0] mdiff;
	logic [58:0] abs_p;
	logic signed [25:0] q_sgn;
	logic [49:0] lsq;
	logic        last_i, full, skip;
	logic signed [23:0] bx, by, nx_a, ny_a, nx_b, ny_b, vx, vy;
	logic [56:0] gsum;

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	assign n_sub = (subs_q == 5'd0) ? 5'd1 : ((subs_q > 5'd16) ? 5'd16 : subs_q);
	assign rd_x  = cur_rd_q[47:24];
	assign rd_y  = cur_rd_q[23:0];
	assign prv_x = prev_rd_q[47:24];
	assign prv_y = prev_rd_q[23:0];
	assign lim_raw = $signed({1'b0, brad_q}) - $signed({7'b0, rad_rd_q});
	assign rsum  = {1'b0, ra_q} + {1'b0, rad_rd_q};
	assign mdiff = $signed({1'b0, mag_q}) - $signed({7'b0, lim_q});
	assign abs_p = prod_q[58] ? 59'(-prod_q) : 59'(prod_q);
	assign q_sgn = neg_q ? -$signed({1'b0, dv_quo_q[24:0]}) : $signed({1'b0, dv_quo_q[24:0]});
	assign lsq   = prod_q[49:0];
	assign last_i = ({1'b0, i_q} == (cnt_q - 7'd1));
	assign full  = (cnt_q == 7'(vcps_pkg::MAX_PARTICLES));
	assign skip  = (dsq_q == 50'd0) || (pair_q ? (dsq_q >= lsq) : (dsq_q <= lsq));

	assign bx   = vcps_pkg::sat28($signed({8'b0, cx_q, 8'b0}) + 28'(sx_q));
	assign by   = vcps_pkg::sat28($signed({8'b0, cy_q, 8'b0}) + 28'(q_sgn));
	assign nx_a = vcps_pkg::sat28(28'(px_q) + 28'(sx_q));
	assign ny_a = vcps_pkg::sat28(28'(py_q) + 28'(q_sgn));
	assign nx_b = vcps_pkg::sat28(28'(qx_q) - 28'(sx_q));
	assign ny_b = vcps_pkg::sat28(28'(qy_q) - 28'(q_sgn));
	assign vx   = vcps_pkg::sat28(28'(rd_x) + 28'(rd_x) - 28'(prv_x));
	assign vy   = vcps_pkg::sat28(28'(rd_y) + 28'(rd_y) - 28'(prv_y)
		+ $signed({3'b0, gs_q}));
	assign gsum = {1'b0, prod_q[55:0]} + (57'd1 << 31);

	// shared divider step: restoring, one quotient bit per cycle
	assign dv_sh = {dv_rem_q[25:0], dv_quo_q[47]};
	assign dv_ge = (dv_sh >= {1'b0, dv_den_q});

	// shared square root step: two radicand bits per cycle
	assign sq_sum = sq_res_q + {2'b0, sq_bit_q};
	assign sq_ge  = ({1'b0, sq_v_q} >= sq_sum);

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		a_d      = a_q;
		b_d      = b_q;
		step_d   = step_q;
		pair_d   = pair_q;
		req_ready = 1'b0;
		rd_addr  = i_q;
		mul_a    = '0;
		mul_b    = '0;
		dv_load  = 1'b0;
		dv_num   = '0;
		dv_den   = '0;
		dv_n     = '0;
		sq_load  = 1'b0;
		cur_we   = 1'b0;
		prev_we  = 1'b0;
		rad_we   = 1'b0;
		wr_addr  = i_q;
		cur_wd   = {bx, by};
		prev_wd  = cur_rd_q;
		rad_wd   = ra_q;
		rsp_load = 1'b0;
		rsp_d    = '0;
		unique case (state_q)
			vcps_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req.req_type == vcps_pkg::REQ_INSERT) begin
						state_d = vcps_pkg::S_INS;
					end else if (cnt_q != 7'd0) begin
						dv_load = 1'b1;
						dv_num  = {req.frame_dt, 32'b0};
						dv_n    = 6'd24;
						dv_den  = {21'b0, n_sub};
						state_d = vcps_pkg::S_SD;
					end
				end
			end
			vcps_pkg::S_INS: begin
				if (out_free) begin
					rsp_load    = 1'b1;
					rsp_d.kind  = vcps_pkg::KIND_ACK;
					rsp_d.last  = 1'b1;
					if (full) begin
						rsp_d.status = vcps_pkg::STATUS_FULL;
					end else begin
						wr_addr = cnt_q[5:0];
						cur_we  = 1'b1;
						prev_we = 1'b1;
						rad_we  = 1'b1;
						cur_wd  = {px_q, py_q};
						prev_wd = {px_q, py_q};
						rsp_d.status     = vcps_pkg::STATUS_OK;
						rsp_d.slot       = cnt_q[5:0];
						rsp_d.out_x      = px_q;
						rsp_d.out_y      = py_q;
						rsp_d.out_radius = ra_q;
					end
					state_d = vcps_pkg::S_IDLE;
				end
			end
			vcps_pkg::S_SD: begin
				if (dv_cnt_q == 6'd0) state_d = vcps_pkg::S_G1;
			end
			vcps_pkg::S_G1: begin
				mul_a   = $signed({9'b0, grav_q});
				mul_b   = $signed({2'b0, sd_q});
				state_d = vcps_pkg::S_G2;
			end
			vcps_pkg::S_G2: begin
				mul_a   = $signed({1'b0, prod_q[47:16]});
				mul_b   = $signed({2'b0, sd_q});
				state_d = vcps_pkg::S_G3;
			end
			vcps_pkg::S_G3: begin
				i_d     = '0;
				step_d  = n_sub;
				pair_d  = 1'b0;
				state_d = vcps_pkg::S_BRD;
			end
			vcps_pkg::S_BRD: state_d = vcps_pkg::S_BLD;
			vcps_pkg::S_BLD: state_d = vcps_pkg::S_M1;
			vcps_pkg::S_PRA: begin
				rd_addr = a_q;
				state_d = vcps_pkg::S_PLA;
			end
			vcps_pkg::S_PLA: begin
				b_d     = a_q - 6'd1;
				state_d = vcps_pkg::S_PRB;
			end
			vcps_pkg::S_PRB: begin
				rd_addr = b_q;
				state_d = vcps_pkg::S_PLB;
			end
			vcps_pkg::S_PLB: state_d = vcps_pkg::S_M1;
			vcps_pkg::S_M1: begin
				mul_a   = 33'(dx_q);
				mul_b   = 26'(dx_q);
				state_d = vcps_pkg::S_M2;
			end
			vcps_pkg::S_M2: begin
				mul_a   = 33'(dy_q);
				mul_b   = 26'(dy_q);
				state_d = vcps_pkg::S_M3;
			end
			vcps_pkg::S_M3: begin
				mul_a   = $signed({13'b0, lim_q});
				mul_b   = $signed({6'b0, lim_q});
				state_d = vcps_pkg::S_CMP;
			end
			vcps_pkg::S_CMP: begin
				if (skip) begin
					state_d = pair_q ? vcps_pkg::S_PNXT : vcps_pkg::S_BNXT;
				end else begin
					sq_load = 1'b1;
					state_d = vcps_pkg::S_SQ;
				end
			end
			vcps_pkg::S_SQ: begin
				if (sq_bit_q == 49'd0) state_d = vcps_pkg::S_MX;
			end
			vcps_pkg::S_MX, vcps_pkg::S_MY: begin
				mul_a   = (state_q == vcps_pkg::S_MX) ? 33'(dx_q) : 33'(dy_q);
				mul_b   = pair_q ? mdiff[25:0] : $signed({6'b0, lim_q});
				state_d = (state_q == vcps_pkg::S_MX) ? vcps_pkg::S_DX0 : vcps_pkg::S_DY0;
			end
			vcps_pkg::S_DX0, vcps_pkg::S_DY0: begin
				dv_load = 1'b1;
				dv_num  = pair_q ? {abs_p[30:0], 17'b0} : {abs_p[44:0], 3'b0};
				dv_n    = pair_q ? 6'd31 : 6'd45;
				dv_den  = pair_q ? {mag_q[24:0], 1'b0} : mag_q;
				state_d = (state_q == vcps_pkg::S_DX0) ? vcps_pkg::S_DX : vcps_pkg::S_DY;
			end
			vcps_pkg::S_DX: begin
				if (dv_cnt_q == 6'd0) state_d = vcps_pkg::S_MY;
			end
			vcps_pkg::S_DY: begin
				if (dv_cnt_q == 6'd0) begin
					cur_we = 1'b1;
					if (pair_q) begin
						wr_addr = b_q;
						cur_wd  = {nx_b, ny_b};
						state_d = vcps_pkg::S_PNXT;
					end else begin
						state_d = vcps_pkg::S_BNXT;
					end
				end
			end
			vcps_pkg::S_BNXT: begin
				if (last_i) begin
					if (cnt_q >= 7'd2) begin
						a_d     = 6'(cnt_q - 7'd1);
						pair_d  = 1'b1;
						state_d = vcps_pkg::S_PRA;
					end else begin
						i_d     = '0;
						state_d = vcps_pkg::S_VRD;
					end
				end else begin
					i_d     = i_q + 6'd1;
					state_d = vcps_pkg::S_BRD;
				end
			end
			vcps_pkg::S_PNXT: begin
				if (b_q == 6'd0) begin
					state_d = vcps_pkg::S_PWA;
				end else begin
					b_d     = b_q - 6'd1;
					state_d = vcps_pkg::S_PRB;
				end
			end
			vcps_pkg::S_PWA: begin
				cur_we  = 1'b1;
				wr_addr = a_q;
				cur_wd  = {px_q, py_q};
				if (a_q == 6'd1) begin
					i_d     = '0;
					pair_d  = 1'b0;
					state_d = vcps_pkg::S_VRD;
				end else begin
					a_d     = a_q - 6'd1;
					state_d = vcps_pkg::S_PRA;
				end
			end
			vcps_pkg::S_VRD: state_d = vcps_pkg::S_VWR;
			vcps_pkg::S_VWR: begin
				cur_we  = 1'b1;
				prev_we = 1'b1;
				cur_wd  = {vx, vy};
				if (last_i) begin
					i_d = '0;
					if (step_q == 5'd1) begin
						state_d = vcps_pkg::S_RRD;
					end else begin
						step_d  = step_q - 5'd1;
						state_d = vcps_pkg::S_BRD;
					end
				end else begin
					i_d     = i_q + 6'd1;
					state_d = vcps_pkg::S_VRD;
				end
			end
			vcps_pkg::S_RRD: state_d = vcps_pkg::S_ROUT;
			vcps_pkg::S_ROUT: begin
				if (out_free) begin
					rsp_load         = 1'b1;
					rsp_d.kind       = vcps_pkg::KIND_POS;
					rsp_d.status     = vcps_pkg::STATUS_OK;
					rsp_d.slot       = i_q;
					rsp_d.out_x      = rd_x;
					rsp_d.out_y      = rd_y;
					rsp_d.out_radius = rad_rd_q;
					rsp_d.last       = last_i;
					if (last_i) begin
						state_d = vcps_pkg::S_IDLE;
					end else begin
						i_d     = i_q + 6'd1;
						state_d = vcps_pkg::S_RRD;
					end
				end
			end
			default: state_d = vcps_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vcps_pkg::S_IDLE;
			i_q         <= '0;
			a_q         <= '0;
			b_q         <= '0;
			step_q      <= '0;
			pair_q      <= 1'b0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			grav_q      <= 24'd256000;
			cx_q        <= 12'd500;
			cy_q        <= 12'd500;
			brad_q      <= 12'd400;
			subs_q      <= 5'd8;
			dv_cnt_q    <= '0;
			sq_bit_q    <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			a_q     <= a_d;
			b_q     <= b_d;
			step_q  <= step_d;
			pair_q  <= pair_d;
			if (state_q == vcps_pkg::S_INS && out_free && !full) cnt_q <= cnt_q + 7'd1;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					vcps_pkg::REG_GRAVITY:      grav_q <= cfg_data;
					vcps_pkg::REG_CENTRE_X:     cx_q   <= cfg_data[11:0];
					vcps_pkg::REG_CENTRE_Y:     cy_q   <= cfg_data[11:0];
					vcps_pkg::REG_BOUND_RADIUS: brad_q <= cfg_data[11:0];
					vcps_pkg::REG_SUBSTEPS:     subs_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (dv_load) begin
				dv_cnt_q <= dv_n;
			end else if (dv_cnt_q != 6'd0) begin
				dv_cnt_q <= dv_cnt_q - 6'd1;
			end
			if (sq_load) begin
				sq_bit_q <= 49'd1 << 48;
			end else if (sq_bit_q != 49'd0) begin
				sq_bit_q <= sq_bit_q >> 2;
			end
		end
	end

	// divider and square root datapaths
	always_ff @(posedge clk) begin
		if (dv_load) begin
			dv_quo_q <= dv_num;
			dv_rem_q <= '0;
			dv_den_q <= dv_den;
		end else if (dv_cnt_q != 6'd0) begin
			dv_rem_q <= dv_ge ? (dv_sh - {1'b0, dv_den_q}) : dv_sh;
			dv_quo_q <= {dv_quo_q[46:0], dv_ge};
		end
		if (sq_load) begin
			sq_v_q   <= dsq_q;
			sq_res_q <= '0;
		end else if (sq_bit_q != 49'd0) begin
			if (sq_ge) begin
				sq_v_q   <= sq_v_q - sq_sum[49:0];
				sq_res_q <= (sq_res_q >> 1) + {2'b0, sq_bit_q};
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
		end
		prod_q <= mul_a * mul_b;
		if (rsp_load) rsp_q <= rsp_d;
	end

	// particle store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cur_we)  cur_mem[wr_addr]  <= cur_wd;
		if (prev_we) prev_mem[wr_addr] <= prev_wd;
		if (rad_we)  rad_mem[wr_addr]  <= rad_wd;
		cur_rd_q  <= cur_mem[rd_addr];
		prev_rd_q <= prev_mem[rd_addr];
		rad_rd_q  <= rad_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			vcps_pkg::S_IDLE: begin
				if (req_valid) begin
					px_q <= req.spawn_x;
					py_q <= req.spawn_y;
					ra_q <= req.spawn_radius;
				end
			end
			vcps_pkg::S_SD: begin
				if (dv_cnt_q == 6'd0) sd_q <= dv_quo_q[23:0];
			end
			vcps_pkg::S_G3: gs_q <= gsum[56:32];
			vcps_pkg::S_BLD: begin
				dx_q  <= 25'(rd_x) - $signed({5'b0, cx_q, 8'b0});
				dy_q  <= 25'(rd_y) - $signed({5'b0, cy_q, 8'b0});
				lim_q <= lim_raw[12] ? 20'd0 : {lim_raw[11:0], 8'b0};
			end
			vcps_pkg::S_PLA: begin
				px_q <= rd_x;
				py_q <= rd_y;
				ra_q <= rad_rd_q;
			end
			vcps_pkg::S_PLB: begin
				qx_q  <= rd_x;
				qy_q  <= rd_y;
				dx_q  <= 25'(rd_x) - 25'(px_q);
				dy_q  <= 25'(rd_y) - 25'(py_q);
				lim_q <= {5'b0, rsum, 8'b0};
			end
			vcps_pkg::S_M2: dsq_q <= prod_q[49:0];
			vcps_pkg::S_M3: dsq_q <= dsq_q + prod_q[49:0];
			vcps_pkg::S_SQ: begin
				if (sq_bit_q == 49'd0) mag_q <= sq_res_q[25:0];
			end
			vcps_pkg::S_DX0, vcps_pkg::S_DY0: neg_q <= prod_q[58];
			vcps_pkg::S_DX: begin
				if (dv_cnt_q == 6'd0) sx_q <= q_sgn;
			end
			vcps_pkg::S_DY: begin
				// hold the newer particle in registers across its inner loop
				if (dv_cnt_q == 6'd0 && pair_q) begin
					px_q <= nx_a;
					py_q <= ny_a;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- dv/tb_verlet_circle_particle_step.sv -----
`timescale 1ns / 1ps

module tb_verlet_circle_particle_step;

	localparam longint CYCLE_LIMIT = 20000000;
	localparam int SETTLE = 300;
	localparam longint POS_HI = 8388607;
	localparam longint POS_LO = -8388608;
	localparam int FRAC = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid;
	logic req_ready;
	vcps_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	vcps_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	vcps_pkg::req_t pending_reqs[$];
	vcps_pkg::rsp_t expected_rsps[$];
	int errors = 0;
	longint cycles = 0;
	int req_gap;
	int rsp_stall;

	// world copy
	longint unsigned w_gravity;
	longint unsigned w_cx, w_cy, w_bound, w_substeps;
	longint w_cur_x[vcps_pkg::MAX_PARTICLES];
	longint w_cur_y[vcps_pkg::MAX_PARTICLES];
	longint w_prev_x[vcps_pkg::MAX_PARTICLES];
	longint w_prev_y[vcps_pkg::MAX_PARTICLES];
	longint w_rad[vcps_pkg::MAX_PARTICLES];
	int w_count;

	verlet_circle_particle_step i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 10) return 0;
		if (pick < 18) return $urandom_range(1, 3);
		return $urandom_range(20, 120);
	endfunction

	function automatic longint sat24(input longint v);
		if (v > POS_HI) return POS_HI;
		if (v < POS_LO) return POS_LO;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > v) bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v = v - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned square(input longint v);
		longint unsigned m;
		m = (v < 0) ? -v : v;
		return m * m;
	endfunction

	task automatic project_to_bound();
		longint cx, cy, lim, limq, dx, dy, mag;
		longint unsigned dsq;
		cx = longint'(w_cx) << FRAC;
		cy = longint'(w_cy) << FRAC;
		for (int i = 0; i < w_count; i++) begin
			lim = longint'(w_bound) - w_rad[i];
			if (lim < 0) lim = 0;
			limq = lim << FRAC;
			dx = w_cur_x[i] - cx;
			dy = w_cur_y[i] - cy;
			dsq = square(dx) + square(dy);
			if (dsq != 0 && dsq > square(limq)) begin
				mag = longint'(int_sqrt(dsq));
				w_cur_x[i] = sat24(cx + dx * limq / mag);
				w_cur_y[i] = sat24(cy + dy * limq / mag);
			end
		end
	endtask

	task automatic separate_pairs();
		longint dx, dy, rs, mag, sx, sy;
		longint unsigned dsq;
		for (int a = w_count - 1; a >= 1; a--) begin
			for (int b = a - 1; b >= 0; b--) begin
				dx = w_cur_x[b] - w_cur_x[a];
				dy = w_cur_y[b] - w_cur_y[a];
				rs = (w_rad[a] + w_rad[b]) << FRAC;
				dsq = square(dx) + square(dy);
				// skip coincident pairs and pairs that do not overlap
				if (dsq != 0 && dsq < square(rs)) begin
					mag = longint'(int_sqrt(dsq));
					sx = dx * (mag - rs) / (2 * mag);
					sy = dy * (mag - rs) / (2 * mag);
					w_cur_x[a] = sat24(w_cur_x[a] + sx);
					w_cur_y[a] = sat24(w_cur_y[a] + sy);
					w_cur_x[b] = sat24(w_cur_x[b] - sx);
					w_cur_y[b] = sat24(w_cur_y[b] - sy);
				end
			end
		end
	endtask

	task automatic advance_world(input logic [15:0] dt);
		longint unsigned n, sd, acc, gs;
		longint nx, ny;
		vcps_pkg::rsp_t r;
		n = (w_substeps == 0) ? 64'd1 : ((w_substeps > 16) ? 64'd16 : w_substeps);
		sd = (longint'(dt) << 8) / n;
		acc = (w_gravity * sd) >> 16;
		gs = (acc * sd + (64'd1 << (39 - FRAC))) >> (40 - FRAC);
		for (longint unsigned s = 0; s < n; s++) begin
			project_to_bound();
			separate_pairs();
			for (int i = 0; i < w_count; i++) begin
				nx = 2 * w_cur_x[i] - w_prev_x[i];
				ny = 2 * w_cur_y[i] - w_prev_y[i] + longint'(gs);
				w_prev_x[i] = w_cur_x[i];
				w_prev_y[i] = w_cur_y[i];
				w_cur_x[i] = sat24(nx);
				w_cur_y[i] = sat24(ny);
			end
		end
		for (int i = 0; i < w_count; i++) begin
			r.kind = vcps_pkg::KIND_POS;
			r.status = vcps_pkg::STATUS_OK;
			r.slot = i[5:0];
			r.out_x = w_cur_x[i][23:0];
			r.out_y = w_cur_y[i][23:0];
			r.out_radius = w_rad[i][5:0];
			r.last = (i == w_count - 1);
			expected_rsps.push_back(r);
		end
	endtask

	task automatic apply_request(input vcps_pkg::req_t q);
		vcps_pkg::rsp_t r;
		r = '0;
		if (q.req_type == vcps_pkg::REQ_INSERT) begin
			r.kind = vcps_pkg::KIND_ACK;
			r.last = 1'b1;
			if (w_count >= vcps_pkg::MAX_PARTICLES) begin
				r.status = vcps_pkg::STATUS_FULL;
			end else begin
				w_cur_x[w_count] = longint'(q.spawn_x);
				w_cur_y[w_count] = longint'(q.spawn_y);
				w_prev_x[w_count] = longint'(q.spawn_x);
				w_prev_y[w_count] = longint'(q.spawn_y);
				w_rad[w_count] = longint'(q.spawn_radius);
				r.status = vcps_pkg::STATUS_OK;
				r.slot = w_count[5:0];
				r.out_x = q.spawn_x;
				r.out_y = q.spawn_y;
				r.out_radius = q.spawn_radius;
				w_count++;
			end
			expected_rsps.push_back(r);
		end else begin
			advance_world(q.frame_dt);
		end
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			req_gap <= 0;
		end else begin
			if (req_valid && req_ready) apply_request(req);
			if (!req_valid || req_ready) begin
				if (req_gap > 0) begin
					req_gap <= req_gap - 1;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
					req_gap <= gap_len();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		vcps_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_stall <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					report("unexpected transaction, slot", longint'(rsp.slot), longint'(-1));
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.kind != want.kind)
						report("kind", longint'(rsp.kind), longint'(want.kind));
					if (rsp.status != want.status)
						report("status", longint'(rsp.status), longint'(want.status));
					if (rsp.slot != want.slot)
						report("slot", longint'(rsp.slot), longint'(want.slot));
					if (rsp.out_x != want.out_x)
						report("out_x", longint'(rsp.out_x), longint'(want.out_x));
					if (rsp.out_y != want.out_y)
						report("out_y", longint'(rsp.out_y), longint'(want.out_y));
					if (rsp.out_radius != want.out_radius)
						report("out_radius", longint'(rsp.out_radius),
							longint'(want.out_radius));
					if (rsp.last != want.last)
						report("last", longint'(rsp.last), longint'(want.last));
				end
			end
			if (rsp_stall > 0) begin
				rsp_stall <= rsp_stall - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				if (rsp_valid && rsp_ready) rsp_stall <= gap_len();
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			vcps_pkg::REG_GRAVITY: w_gravity = 64'(val);
			vcps_pkg::REG_CENTRE_X: w_cx = 64'(val[11:0]);
			vcps_pkg::REG_CENTRE_Y: w_cy = 64'(val[11:0]);
			vcps_pkg::REG_BOUND_RADIUS: w_bound = 64'(val[11:0]);
			vcps_pkg::REG_SUBSTEPS: w_substeps = 64'(val[4:0]);
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// hold until every transaction is drained, then let the block settle
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic vcps_pkg::req_t insert_req(input longint x, input longint y,
		input int r);
		vcps_pkg::req_t q;
		q.req_type = vcps_pkg::REQ_INSERT;
		q.spawn_x = x[23:0];
		q.spawn_y = y[23:0];
		q.spawn_radius = r[5:0];
		q.frame_dt = 16'($urandom);
		return q;
	endfunction

	function automatic vcps_pkg::req_t frame_req(input int dt);
		vcps_pkg::req_t q;
		q.req_type = vcps_pkg::REQ_FRAME;
		q.spawn_x = 24'($urandom);
		q.spawn_y = 24'($urandom);
		q.spawn_radius = 6'($urandom);
		q.frame_dt = dt[15:0];
		return q;
	endfunction

	function automatic vcps_pkg::req_t random_insert();
		longint x, y;
		if ($urandom_range(0, 7) == 0) begin
			x = longint'($signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8);
			y = longint'($signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8);
		end else begin
			x = (longint'(w_cx) << FRAC) + $signed($urandom_range(0, 200000)) - 100000;
			y = (longint'(w_cy) << FRAC) + $signed($urandom_range(0, 200000)) - 100000;
		end
		return insert_req(x, y, $urandom_range(0, 63));
	endfunction

	initial begin
		int planned;
		w_gravity = 256000;
		w_cx = 500;
		w_cy = 500;
		w_bound = 400;
		w_substeps = 8;
		w_count = 0;
		planned = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// empty store, then corner placements at reset settings
		pending_reqs.push_back(frame_req(1000));
		wait_drained();
		pending_reqs.push_back(insert_req(longint'(500 << FRAC), longint'(500 << FRAC), 10));
		pending_reqs.push_back(insert_req(longint'(500 << FRAC), longint'(500 << FRAC), 10));
		pending_reqs.push_back(insert_req(longint'((500 << FRAC) + 700),
			longint'(500 << FRAC), 63));
		pending_reqs.push_back(insert_req(64'sd0, 64'sd0, 0));
		pending_reqs.push_back(insert_req(POS_HI, POS_LO, 63));
		pending_reqs.push_back(insert_req(POS_LO, POS_HI, 1));
		pending_reqs.push_back(frame_req(65535));
		pending_reqs.push_back(frame_req(0));
		pending_reqs.push_back(frame_req(1092));
		planned = 6;
		wait_drained();

		write_reg(vcps_pkg::REG_GRAVITY, 24'hFFFFFF);
		write_reg(vcps_pkg::REG_SUBSTEPS, 24'd1);
		write_reg(vcps_pkg::REG_CENTRE_X, 24'd0);
		write_reg(vcps_pkg::REG_CENTRE_Y, 24'd4095);
		write_reg(vcps_pkg::REG_BOUND_RADIUS, 24'd0);
		pending_reqs.push_back(frame_req(65535));
		pending_reqs.push_back(frame_req(3000));
		wait_drained();

		write_reg(vcps_pkg::REG_GRAVITY, 24'd0);
		write_reg(vcps_pkg::REG_SUBSTEPS, 24'd0);
		write_reg(vcps_pkg::REG_CENTRE_X, 24'd4095);
		write_reg(vcps_pkg::REG_CENTRE_Y, 24'd0);
		write_reg(vcps_pkg::REG_BOUND_RADIUS, 24'd4095);
		pending_reqs.push_back(frame_req(2000));
		wait_drained();
		write_reg(vcps_pkg::REG_SUBSTEPS, 24'd31);
		pending_reqs.push_back(frame_req(500));
		wait_drained();
		write_reg(vcps_pkg::REG_SUBSTEPS, 24'd16);
		pending_reqs.push_back(frame_req(800));
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(vcps_pkg::REG_GRAVITY, 24'(($urandom_range(0, 3) == 0) ?
				$urandom : $urandom_range(0, 400000)));
			write_reg(vcps_pkg::REG_CENTRE_X, 24'($urandom_range(300, 700)));
			write_reg(vcps_pkg::REG_CENTRE_Y, 24'($urandom_range(300, 700)));
			write_reg(vcps_pkg::REG_BOUND_RADIUS, 24'($urandom_range(100, 500)));
			write_reg(vcps_pkg::REG_SUBSTEPS, 24'($urandom_range(1, 4)));
			for (int k = 0; k < 8; k++) begin
				if (planned < 16 && $urandom_range(0, 1) == 0) begin
					pending_reqs.push_back(random_insert());
					planned++;
				end else begin
					pending_reqs.push_back(frame_req(($urandom_range(0, 9) == 0) ?
						$urandom_range(0, 65535) : $urandom_range(0, 4000)));
				end
			end
			wait_drained();
		end

		// fill the store, overflow it, and run one full frame
		write_reg(vcps_pkg::REG_SUBSTEPS, 24'd1);
		while (planned < vcps_pkg::MAX_PARTICLES + 2) begin
			pending_reqs.push_back(random_insert());
			planned++;
		end
		pending_reqs.push_back(frame_req(500));
		wait_drained();

		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
